// ===== src/page_tag_state_manager_core_defines.svh =====
// ----------------------------------------------------------------------------
// page_tag_state_manager_core_defines.svh
// Assertion macros for the checker. Each expects clk and arst_n
// in scope.
// ----------------------------------------------------------------------------
`ifndef PAGE_TAG_STATE_MANAGER_CORE_DEFINES_SVH
`define PAGE_TAG_STATE_MANAGER_CORE_DEFINES_SVH

// same-cycle implication
`define PTSM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("ptsm assertion failed");

// next-cycle implication
`define PTSM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ptsm assertion failed");

`endif

// ===== src/ptsm_pkg.sv =====
// ----------------------------------------------------------------------------
// ptsm_pkg
// Types, codes and helpers for the page tag state manager.
// ----------------------------------------------------------------------------
package ptsm_pkg;

	localparam int unsigned POOL_COUNT_DEF = 2;
	localparam int unsigned POOL_PAGES_DEF = 1024;
	localparam int unsigned POOL_REGS      = 2;
	localparam int unsigned PAGE_SHIFT     = 12;
	localparam int unsigned TAG_LSB        = 56;
	localparam int unsigned TAG_W          = 4;
	localparam int unsigned ENTRY_W        = TAG_W + 1;
	localparam int unsigned ALLOC_BIT      = TAG_W;
	localparam int unsigned ADDR_W         = 64;
	localparam int unsigned PGCNT_W        = 11;
	localparam int unsigned CFG_IDX_W      = 3;

	localparam logic [ADDR_W-1:0] TOP_MASK  = 64'hff << TAG_LSB;
	localparam logic [TAG_W-1:0]  TAG_LIMIT = 4'd15;

	// commands
	localparam logic [1:0] CMD_ALLOC   = 2'd0;
	localparam logic [1:0] CMD_FREE    = 2'd1;
	localparam logic [1:0] CMD_XLATE   = 2'd2;
	localparam logic [1:0] CMD_INVALID = 2'd3;

	// response status
	localparam logic [1:0] STATUS_DONE   = 2'd0;
	localparam logic [1:0] STATUS_PASS   = 2'd1;
	localparam logic [1:0] STATUS_REJECT = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_POOL0_BASE  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_POOL0_PAGES = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POOL1_BASE  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_POOL1_PAGES = 3'd4;

	typedef struct packed {
		logic [1:0]        cmd;
		logic [1:0]        owner_pool;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] address_out;
		logic [TAG_W-1:0]  page_tag;
		logic              clear_page;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR  = 3'b001,
		ST_IDLE   = 3'b010,
		ST_LOOKUP = 3'b100
	} state_t;

	typedef struct packed {
		logic clear_en;
		logic capture;
		logic finish;
	} ctrl_cmd_t;

	typedef struct packed {
		logic clear_done;
	} dp_stat_t;

	function automatic logic [ADDR_W-1:0] put_tag(logic [ADDR_W-1:0] a,
			logic [TAG_W-1:0] tag);
		logic [ADDR_W-1:0] r;
		r = a & ~TOP_MASK;
		r[TAG_LSB +: TAG_W] = tag;
		return r;
	endfunction

endpackage

// ===== src/ptsm_ram.sv =====
// ----------------------------------------------------------------------------
// ptsm_ram
// Generic RAM: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ptsm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== src/ptsm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptsm_ctrl
// Sequencer: table clear after reset, request capture, entry write-back and
// response register handshake.
// ----------------------------------------------------------------------------
module ptsm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	input  ptsm_pkg::dp_stat_t  stat,
	output ptsm_pkg::ctrl_cmd_t ctl
);

	ptsm_pkg::state_t state_q, state_d;
	logic             rsp_valid_q;

	always_comb begin
		req_ready    = (state_q == ptsm_pkg::ST_IDLE);
		ctl.clear_en = (state_q == ptsm_pkg::ST_CLEAR);
		ctl.capture  = req_valid && req_ready;
		// result may load when the output register is empty or being drained
		ctl.finish   = (state_q == ptsm_pkg::ST_LOOKUP) && (!rsp_valid_q || rsp_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ptsm_pkg::ST_CLEAR: begin
				if (stat.clear_done) state_d = ptsm_pkg::ST_IDLE;
			end
			ptsm_pkg::ST_IDLE: begin
				if (ctl.capture) state_d = ptsm_pkg::ST_LOOKUP;
			end
			ptsm_pkg::ST_LOOKUP: begin
				if (ctl.finish) state_d = ptsm_pkg::ST_IDLE;
			end
			default: state_d = ptsm_pkg::ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ptsm_pkg::ST_CLEAR;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.finish) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;

endmodule

// ===== src/ptsm_dp.sv =====
// ----------------------------------------------------------------------------
// ptsm_dp
// Datapath: configuration registers, pool range checks, tag table RAM,
// tag update and response register.
// ----------------------------------------------------------------------------
module ptsm_dp #(
	parameter int unsigned POOL_COUNT = ptsm_pkg::POOL_COUNT_DEF,
	parameter int unsigned POOL_PAGES = ptsm_pkg::POOL_PAGES_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [ptsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [ptsm_pkg::ADDR_W-1:0]        cfg_data,
	input  ptsm_pkg::req_t                     req,
	input  ptsm_pkg::ctrl_cmd_t                ctl,
	output ptsm_pkg::dp_stat_t                 stat,
	output ptsm_pkg::rsp_t                     rsp
);

	localparam int unsigned DEPTH = POOL_COUNT * POOL_PAGES;
	localparam int unsigned AW    = $clog2(DEPTH);
	localparam int unsigned PW    = $clog2(POOL_PAGES);
	localparam int unsigned CW    = (ptsm_pkg::PGCNT_W > $clog2(POOL_PAGES + 1)) ?
	                                ptsm_pkg::PGCNT_W : $clog2(POOL_PAGES + 1);
	localparam int unsigned PS    = ptsm_pkg::PAGE_SHIFT;
	localparam int unsigned TW    = ptsm_pkg::TAG_W;
	localparam int unsigned EW    = ptsm_pkg::ENTRY_W;

	localparam logic [1:0] KIND_REJECT = 2'd0;
	localparam logic [1:0] KIND_PASS   = 2'd1;
	localparam logic [1:0] KIND_TABLE  = 2'd2;

	// configuration
	logic                              active_q;
	logic [ptsm_pkg::ADDR_W-1:0]       base_q  [ptsm_pkg::POOL_REGS];
	logic [ptsm_pkg::PGCNT_W-1:0]      pages_q [ptsm_pkg::POOL_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			base_q[0]  <= '0;
			base_q[1]  <= '0;
			pages_q[0] <= '0;
			pages_q[1] <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				ptsm_pkg::REG_ACTIVE:      active_q   <= cfg_data[0];
				ptsm_pkg::REG_POOL0_BASE:  base_q[0]  <= cfg_data;
				ptsm_pkg::REG_POOL0_PAGES: pages_q[0] <= cfg_data[ptsm_pkg::PGCNT_W-1:0];
				ptsm_pkg::REG_POOL1_BASE:  base_q[1]  <= cfg_data;
				ptsm_pkg::REG_POOL1_PAGES: pages_q[1] <= cfg_data[ptsm_pkg::PGCNT_W-1:0];
				default: ;
			endcase
		end
	end

	// pool lanes, one subtract/compare each
	logic [ptsm_pkg::ADDR_W-1:0]  raw, lane_addr;
	logic                         need_align;
	logic [ptsm_pkg::POOL_REGS-1:0] hit, used;
	logic [AW-1:0]                lane_idx [ptsm_pkg::POOL_REGS];

	assign raw        = req.address & ~ptsm_pkg::TOP_MASK;
	assign need_align = (req.cmd != ptsm_pkg::CMD_XLATE);
	assign lane_addr  = need_align ? raw : req.address;

	for (genvar p = 0; p < ptsm_pkg::POOL_REGS; p++) begin : g_lane
		logic [ptsm_pkg::ADDR_W-1:0] off, pg;
		logic [CW-1:0]               cnt;
		logic                        ge, align_bad, lane_used, lane_hit;

		always_comb begin
			lane_used = (p < POOL_COUNT) && (pages_q[p] != '0);
			ge        = (lane_addr >= base_q[p]);
			off       = lane_addr - base_q[p];
			pg        = off >> PS;
			cnt       = (CW'(pages_q[p]) > CW'(POOL_PAGES)) ? CW'(POOL_PAGES) : CW'(pages_q[p]);
			align_bad = (off[PS-1:0] != '0) ||
			            ((base_q[p][PS-1:0] != '0) && (lane_addr[PS-1:0] != '0));
			lane_hit  = lane_used && ge && (pg < ptsm_pkg::ADDR_W'(cnt)) &&
			            !(need_align && align_bad);
		end

		assign used[p]     = lane_used;
		assign hit[p]      = lane_hit;
		assign lane_idx[p] = AW'(p * POOL_PAGES) + AW'(pg[PW-1:0]);
	end

	// request classification
	logic [1:0]    kind_d;
	logic [AW-1:0] tidx_d;
	logic          own;

	assign own = req.owner_pool[0];

	always_comb begin
		kind_d = KIND_PASS;
		tidx_d = lane_idx[0];
		if (req.cmd == ptsm_pkg::CMD_INVALID) begin
			kind_d = KIND_REJECT;
		end else if (!active_q) begin
			kind_d = KIND_PASS;
		end else if (req.cmd == ptsm_pkg::CMD_XLATE) begin
			// lowest pool wins on overlap
			if (hit[0]) begin
				kind_d = KIND_TABLE;
			end else if (hit[1]) begin
				kind_d = KIND_TABLE;
				tidx_d = lane_idx[1];
			end
		end else if (req.owner_pool[1] || !(own ? used[1] : used[0])) begin
			kind_d = KIND_PASS;
		end else begin
			kind_d = (own ? hit[1] : hit[0]) ? KIND_TABLE : KIND_REJECT;
			tidx_d = own ? lane_idx[1] : lane_idx[0];
		end
	end

	logic [1:0]                  cmd_q, kind_q;
	logic [ptsm_pkg::ADDR_W-1:0] addr_q;
	logic [AW-1:0]               tidx_q;

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			cmd_q  <= req.cmd;
			kind_q <= kind_d;
			addr_q <= req.address;
			tidx_q <= tidx_d;
		end
	end

	// table RAM and clear sweep
	logic [AW-1:0] clr_cnt_q;
	logic [EW-1:0] rd_data, wr_entry;
	logic          wr_ok;

	assign stat.clear_done = (clr_cnt_q == AW'(DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
		end else if (ctl.clear_en && !stat.clear_done) begin
			clr_cnt_q <= clr_cnt_q + AW'(1);
		end
	end

	ptsm_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ctl.clear_en || (ctl.finish && wr_ok)),
		.waddr(ctl.clear_en ? clr_cnt_q : tidx_q),
		.wdata(ctl.clear_en ? '0 : wr_entry),
		.re   (ctl.capture),
		.raddr(tidx_d),
		.rdata(rd_data)
	);

	// result and entry update
	ptsm_pkg::rsp_t              rsp_d, rsp_q;
	logic [TW-1:0]               tag_old, tag_new;
	logic                        alloc_old;
	logic [ptsm_pkg::ADDR_W-1:0] raw_q;

	always_comb begin
		alloc_old = rd_data[ptsm_pkg::ALLOC_BIT];
		tag_old   = rd_data[TW-1:0];
		tag_new   = (tag_old == ptsm_pkg::TAG_LIMIT) ? TW'(1) : tag_old + TW'(1);
		raw_q     = addr_q & ~ptsm_pkg::TOP_MASK;
		wr_ok     = 1'b0;
		wr_entry  = rd_data;
		rsp_d.status      = ptsm_pkg::STATUS_REJECT;
		rsp_d.address_out = '0;
		rsp_d.page_tag    = '0;
		rsp_d.clear_page  = 1'b0;
		case (kind_q)
			KIND_PASS: begin
				rsp_d.status      = ptsm_pkg::STATUS_PASS;
				rsp_d.address_out = addr_q;
			end
			KIND_TABLE: begin
				case (cmd_q)
					ptsm_pkg::CMD_XLATE: begin
						if (!alloc_old) begin
							rsp_d.status      = ptsm_pkg::STATUS_PASS;
							rsp_d.address_out = addr_q;
						end else begin
							rsp_d.status      = ptsm_pkg::STATUS_DONE;
							rsp_d.address_out = ptsm_pkg::put_tag(addr_q, tag_old);
							rsp_d.page_tag    = tag_old;
						end
					end
					ptsm_pkg::CMD_ALLOC: begin
						if (!alloc_old) begin
							wr_ok             = 1'b1;
							wr_entry          = {1'b1, tag_new};
							rsp_d.status      = ptsm_pkg::STATUS_DONE;
							rsp_d.address_out = ptsm_pkg::put_tag(raw_q, tag_new);
							rsp_d.page_tag    = tag_new;
							rsp_d.clear_page  = 1'b1;
						end
					end
					ptsm_pkg::CMD_FREE: begin
						// pointer tag must match; tag is kept on free
						if (alloc_old && (tag_old == addr_q[ptsm_pkg::TAG_LSB +: TW])) begin
							wr_ok             = 1'b1;
							wr_entry          = {1'b0, tag_old};
							rsp_d.status      = ptsm_pkg::STATUS_DONE;
							rsp_d.address_out = raw_q;
							rsp_d.clear_page  = 1'b1;
						end
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctl.finish) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp = rsp_q;

endmodule

// ===== src/page_tag_state_manager_core.sv =====
// Requests: an accepted request moves to the LOOKUP state while its table entry is read;
// the response register then loads once it is empty or being drained, raising rsp_valid.
// req_ready stays low until then; each request reads and then writes back
// one tag table entry through the table RAM's read port and write port.
// Reset: asynchronous; afterwards the table is swept to zero, one entry per
// cycle over all POOL_COUNT*POOL_PAGES entries (2048 by default), with req_ready
// low. Configuration writes are taken at any time, also during the sweep.
// ----------------------------------------------------------------------------
// page_tag_state_manager_core
// Per-page allocated bit and memory tag for two page pools: allocate, free
// and translate requests with one response each.
// ----------------------------------------------------------------------------
module page_tag_state_manager_core #(
	parameter int unsigned POOL_COUNT = ptsm_pkg::POOL_COUNT_DEF,
	parameter int unsigned POOL_PAGES = ptsm_pkg::POOL_PAGES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ptsm_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ptsm_pkg::ADDR_W-1:0]    cfg_data,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  ptsm_pkg::req_t                 req,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output ptsm_pkg::rsp_t                 rsp
);

	ptsm_pkg::ctrl_cmd_t ctl;
	ptsm_pkg::dp_stat_t  stat;

	ptsm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.stat     (stat),
		.ctl      (ctl)
	);

	ptsm_dp #(
		.POOL_COUNT(POOL_COUNT),
		.POOL_PAGES(POOL_PAGES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req),
		.ctl      (ctl),
		.stat     (stat),
		.rsp      (rsp)
	);

endmodule

// ===== src/ptsm_checker.sv =====
// ----------------------------------------------------------------------------
// ptsm_checker
// Port-level checks for the page tag state manager, bound to the top level.
// ----------------------------------------------------------------------------
`include "page_tag_state_manager_core_defines.svh"

module ptsm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_ready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input ptsm_pkg::rsp_t rsp
);

	logic rsp_untagged, rsp_empty;

	assign rsp_untagged = (rsp.page_tag == '0) && !rsp.clear_page;
	assign rsp_empty    = rsp_untagged && (rsp.address_out == '0);

	// one request in flight at a time
	`PTSM_ASSERT_NXT(a_one_in_flight, req_valid && req_ready, !req_ready)

	// a waiting response holds
	`PTSM_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp))

	// rejected responses carry nothing
	`PTSM_ASSERT_IMP(a_reject_empty, rsp_valid && (rsp.status == ptsm_pkg::STATUS_REJECT), rsp_empty)

	// only a completed alloc or free asks for a page clear
	`PTSM_ASSERT_IMP(a_clear_done, rsp_valid && rsp.clear_page, rsp.status == ptsm_pkg::STATUS_DONE)

	// pass-through never tags
	`PTSM_ASSERT_IMP(a_pass_untagged, rsp_valid && (rsp.status == ptsm_pkg::STATUS_PASS), rsp_untagged)

endmodule

bind page_tag_state_manager_core ptsm_checker u_ptsm_checker (.*);
